[src/sseg_pkg.sv]
// Shared types, constants and the digit-to-segment function for the
// seven-segment number display. No dependencies.
package sseg_pkg;

	localparam int BIN_W    = 32;
	localparam int RAW_W    = 32;
	localparam int CODE_W   = 8;
	localparam int ENABLE_W = 4;
	localparam int PLACE_W  = 2;
	localparam int OP_W     = 2;
	localparam int STEP_W   = $clog2(BIN_W);
	localparam int BCD_W    = 4;

	localparam logic [OP_W-1:0] OP_NUMBER = 2'd0;
	localparam logic [OP_W-1:0] OP_SCAN   = 2'd1;
	localparam logic [OP_W-1:0] OP_RAW    = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [BIN_W-1:0]   number_value;
		logic [RAW_W-1:0]   raw_codes;
		logic [PLACE_W-1:0] digit_place;
	} sseg_in_t;

	typedef struct packed {
		logic [ENABLE_W-1:0] digit_enable_n;
		logic [CODE_W-1:0]   segment_code;
	} sseg_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_WRITE
	} sseg_state_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic write_num;
		logic write_raw;
		logic scan;
	} sseg_cmd_t;

	typedef struct packed {
		logic last_step;
	} sseg_status_t;

	// Standard gfedcba patterns; anything above nine is blank.
	function automatic logic [CODE_W-1:0] seg_code(input logic [BCD_W-1:0] digit);
		logic [CODE_W-1:0] code;
		unique case (digit)
			4'd0:    code = 8'h3F;
			4'd1:    code = 8'h06;
			4'd2:    code = 8'h5B;
			4'd3:    code = 8'h4F;
			4'd4:    code = 8'h66;
			4'd5:    code = 8'h6D;
			4'd6:    code = 8'h7D;
			4'd7:    code = 8'h07;
			4'd8:    code = 8'h7F;
			4'd9:    code = 8'h6F;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

endpackage

[src/sseg_ctrl.sv]
// Controller state machine for the seven-segment number display.
// Depends on sseg_pkg for the state, command and status types.
module sseg_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            op,
	input  sseg_pkg::sseg_status_t status,
	output sseg_pkg::sseg_cmd_t   cmd,
	output logic                  busy
);
	import sseg_pkg::*;

	sseg_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (op == OP_NUMBER) begin
						cmd.load = 1'b1;
						state_d  = ST_CONVERT;
					end else if (op == OP_RAW) begin
						cmd.write_raw = 1'b1;
					end else if (op == OP_SCAN) begin
						cmd.scan = 1'b1;
					end
				end
			end
			ST_CONVERT: begin
				cmd.shift = 1'b1;
				if (status.last_step) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.write_num = 1'b1;
				state_d       = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[src/sseg_dp.sv]
// Datapath of the seven-segment number display: shift-add-3 converter,
// code store with leading-zero blanking, and the scan result register.
// Depends on sseg_pkg for types, widths and the segment function.
module sseg_dp #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sseg_pkg::sseg_in_t  in_item,
	input  sseg_pkg::sseg_cmd_t cmd,
	output sseg_pkg::sseg_status_t status,
	output logic                done,
	output sseg_pkg::sseg_out_t result
);
	import sseg_pkg::*;

	localparam int IDX_W = $clog2(DIGIT_COUNT);
	localparam int DEC_W = BCD_W * DIGIT_COUNT;

	logic [BIN_W-1:0]  bin_q;
	logic [DEC_W-1:0]  bcd_q;
	logic [DEC_W-1:0]  bcd_adj;
	logic [STEP_W-1:0] step_q;
	logic [CODE_W-1:0] store_q [DIGIT_COUNT];
	logic [CODE_W-1:0] num_codes [DIGIT_COUNT];
	logic              done_q;
	sseg_out_t         result_q;
	sseg_out_t         scan_res;

	assign status.last_step = (step_q == STEP_W'(BIN_W - 1));

	// Digits of five or more get three added before the shift, so that
	// the shift carries correctly into the next decimal digit. Digits
	// above the kept ones are dropped, which keeps the value mod 10^N.
	always_comb begin
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			if (bcd_q[i*BCD_W +: BCD_W] >= 4'd5) begin
				bcd_adj[i*BCD_W +: BCD_W] = bcd_q[i*BCD_W +: BCD_W] + 4'd3;
			end else begin
				bcd_adj[i*BCD_W +: BCD_W] = bcd_q[i*BCD_W +: BCD_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q  <= in_item.number_value;
			bcd_q  <= '0;
			step_q <= '0;
		end else if (cmd.shift) begin
			bin_q  <= bin_q << 1;
			bcd_q  <= {bcd_adj[DEC_W-2:0], bin_q[BIN_W-1]};
			step_q <= step_q + STEP_W'(1);
		end
	end

	// Leading zeros are blanked from the top down; the lowest digit always shows.
	always_comb begin
		logic shown;
		logic [BCD_W-1:0] dig;
		shown = 1'b0;
		for (int i = DIGIT_COUNT - 1; i >= 1; i--) begin
			dig = bcd_q[i*BCD_W +: BCD_W];
			if (dig != '0) begin
				shown = 1'b1;
			end
			num_codes[i] = shown ? seg_code(dig) : '0;
		end
		num_codes[0] = seg_code(bcd_q[BCD_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				store_q[i] <= '0;
			end
		end else if (cmd.write_num) begin
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				store_q[i] <= num_codes[i];
			end
		end else if (cmd.write_raw) begin
			// Places above the fourth byte shift out to zero, i.e. blank.
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				store_q[i] <= CODE_W'(in_item.raw_codes >> (CODE_W * i));
			end
		end
	end

	always_comb begin
		if (int'(in_item.digit_place) < DIGIT_COUNT) begin
			scan_res.digit_enable_n = ~(ENABLE_W'(1) << in_item.digit_place);
			scan_res.segment_code   = store_q[IDX_W'(in_item.digit_place)];
		end else begin
			scan_res.digit_enable_n = '1;
			scan_res.segment_code   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.scan;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			result_q <= scan_res;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[src/seven_segment_number_display.sv]
// Four-digit multiplexed seven-segment display driver, top level.
// A scan item gives its result in the cycle after acceptance, with busy staying low, so scans
// can be accepted every cycle while no other item holds busy high. A set-raw item writes the
// store when accepted and leaves busy low. A set-number item keeps busy high through 32
// shift-add-3 steps over the binary value and one store write. Reset clears the code store.
// Depends on sseg_pkg, sseg_ctrl and sseg_dp.
module seven_segment_number_display #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  sseg_pkg::sseg_in_t in_item,
	output logic               done,
	output sseg_pkg::sseg_out_t result
);
	import sseg_pkg::*;

	// The controller sequences each item; the datapath holds the converter,
	// the code store and the result register. They talk only through the
	// command and status structs below.
	sseg_cmd_t    cmd;
	sseg_status_t status;

	// Items are taken only when the controller is idle; a scan result
	// is strobed on done for exactly one cycle and cannot be held off.
	sseg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (in_item.op),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	sseg_dp #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (in_item),
		.cmd     (cmd),
		.status  (status),
		.done    (done),
		.result  (result)
	);

endmodule

[tb/seven_segment_number_display_test.sv]
// Self-checking testbench for the four-digit seven-segment display driver.
// It predicts the code store and every scan result, and checks the results as they come.
// Depends on sseg_pkg and seven_segment_number_display.
module seven_segment_number_display_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sseg_pkg::*;

	// The package names three operations. The fourth code is ignored by the block.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int PLACES       = 4;
	localparam int RANDOM_ITEMS = 1500;
	// A set-number item keeps the block busy through its conversion and gives no result.
	// That is why the end of the run waits out more than a full conversion.
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 500000;

	// The scoreboard keeps its own copy of the code store. Every accepted scan item
	// queues the enables and segment code that the block should return for it.
	class scan_scoreboard;
		logic [CODE_W-1:0] held_codes [PLACES];
		sseg_out_t         pending_scans [$];
		int unsigned       mismatch_count;

		function new();
			foreach (held_codes[i]) held_codes[i] = '0;
			mismatch_count = 0;
		endfunction

		function void note_input(sseg_in_t item);
			logic [CODE_W-1:0] digit_segs [10];
			logic [BIN_W-1:0]  rest;
			logic [3:0]        dec [PLACES];
			bit                lit;
			sseg_out_t         scan_out;
			digit_segs = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
				8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
			case (item.op)
				OP_NUMBER: begin
					rest = item.number_value;
					for (int i = 0; i < PLACES; i++) begin
						dec[i] = 4'(rest % 10);
						rest   = rest / 10;
					end
					// Upper places stay blank until the first nonzero digit from the top.
					// Place 0 always shows its digit, so zero reads as a single 0.
					lit = 1'b0;
					for (int i = PLACES - 1; i >= 1; i--) begin
						if (dec[i] != 0) lit = 1'b1;
						held_codes[i] = lit ? digit_segs[dec[i]] : '0;
					end
					held_codes[0] = digit_segs[dec[0]];
				end
				OP_RAW: begin
					for (int i = 0; i < PLACES; i++)
						held_codes[i] = item.raw_codes[CODE_W*i +: CODE_W];
				end
				OP_SCAN: begin
					scan_out.digit_enable_n = ~(ENABLE_W'(1) << item.digit_place);
					scan_out.segment_code   = held_codes[item.digit_place];
					pending_scans.push_back(scan_out);
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH at %0t ns: %s", $time, what);
			mismatch_count++;
		endtask

		task check_scan(sseg_out_t got);
			sseg_out_t want;
			if (pending_scans.size() == 0) begin
				report_mismatch($sformatf("result %h with no scan item waiting", got));
				return;
			end
			want = pending_scans.pop_front();
			if (got.digit_enable_n !== want.digit_enable_n)
				report_mismatch($sformatf("digit_enable_n %b, predicted %b",
					got.digit_enable_n, want.digit_enable_n));
			if (got.segment_code !== want.segment_code)
				report_mismatch($sformatf("segment_code %h, predicted %h",
					got.segment_code, want.segment_code));
		endtask

		function int pending();
			return pending_scans.size();
		endfunction
	endclass

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	logic      busy;
	sseg_in_t  in_item = '0;
	logic      done;
	sseg_out_t result;

	scan_scoreboard board;
	int             cycle_count = 0;

	seven_segment_number_display #(
		.DIGIT_COUNT(PLACES)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.in_item(in_item),
		.done   (done),
		.result (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The block drives a result for exactly one cycle, and nothing can hold it off.
	// So every strobe seen at a rising edge is checked at once. The testbench reads the
	// outputs in the active region of the edge, which gives the values from before the edge.
	always @(posedge clk) begin
		if (arst_n && done) board.check_scan(result);
	end

	// This is a safety net. Even a slow correct run finishes far below this limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Present one item and hold it until an edge where start is high and busy is low.
	// The caller is at a rising edge when this returns. It can present the next item
	// at once, so start stays high across back-to-back items.
	task send_item(input sseg_in_t item);
		in_item <= item;
		start   <= 1'b1;
		do @(posedge clk); while (busy);
		board.note_input(item);
	endtask

	// Build a directed item. The fields that the operation ignores get random values.
	task send_directed(input logic [OP_W-1:0] op, input logic [31:0] value,
		input logic [PLACE_W-1:0] place);
		sseg_in_t item;
		item.op           = op;
		item.number_value = (op == OP_NUMBER) ? value : $urandom;
		item.raw_codes    = (op == OP_RAW) ? value : $urandom;
		item.digit_place  = (op == OP_SCAN) ? place : PLACE_W'($urandom_range(0, 3));
		send_item(item);
	endtask

	// Stop sending until every queued scan result has come back. At least one
	// edge passes with start low, so the next item starts in a later time step.
	task drain_scans();
		start <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	initial begin
		sseg_in_t item;
		int       sent;
		int       burst;
		int       gap;
		int       pick;
		bit       paused_once;

		board = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// After reset, every place should read blank.
		for (int p = 0; p < PLACES; p++) send_directed(OP_SCAN, '0, PLACE_W'(p));
		// The largest value shows only its low four digits, 7295.
		send_directed(OP_NUMBER, 32'hFFFF_FFFF, '0);
		for (int p = 0; p < PLACES; p++) send_directed(OP_SCAN, '0, PLACE_W'(p));
		// Four low zero digits blank down to a single 0 in place 0.
		send_directed(OP_NUMBER, 32'd10000, '0);
		send_directed(OP_SCAN, '0, 2'd3);
		send_directed(OP_SCAN, '0, 2'd0);
		// A zero between nonzero digits is still shown.
		send_directed(OP_NUMBER, 32'd305, '0);
		send_directed(OP_SCAN, '0, 2'd3);
		send_directed(OP_SCAN, '0, 2'd1);
		send_directed(OP_NUMBER, 32'd0, '0);
		send_directed(OP_SCAN, '0, 2'd0);
		// Raw codes pass through unchanged, including all ones and all zeros.
		send_directed(OP_RAW, 32'hFFFF_FFFF, '0);
		send_directed(OP_SCAN, '0, 2'd3);
		send_directed(OP_RAW, 32'h00A5_5A00, '0);
		send_directed(OP_SCAN, '0, 2'd1);
		send_directed(OP_SCAN, '0, 2'd0);
		// The unused op code should leave the store alone and give no result.
		send_directed(OP_UNUSED, 32'h1234_5678, '0);
		send_directed(OP_SCAN, '0, 2'd2);

		// In the random part, items come in bursts with idle gaps between them.
		// Now and then a long burst runs with no gaps. The gaps vary in length, so they
		// fall at different points of the long set-number conversion.
		sent        = 0;
		paused_once = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
			for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
				pick              = $urandom_range(0, 99);
				item.raw_codes    = $urandom;
				item.digit_place  = PLACE_W'($urandom_range(0, 3));
				item.number_value = $urandom;
				if (pick < 45)      item.op = OP_SCAN;
				else if (pick < 70) item.op = OP_NUMBER;
				else if (pick < 95) item.op = OP_RAW;
				else                item.op = OP_UNUSED;
				// Numbers are mostly short, or a single digit followed by zeros.
				// This exercises leading-zero blanking. Full 32-bit values cover the high bits.
				case ($urandom_range(0, 3))
					0: item.number_value = $urandom_range(0, 9);
					1: item.number_value = $urandom_range(0, 9999);
					2: item.number_value = $urandom_range(0, 9) * (10 ** $urandom_range(0, 4));
					default: ;
				endcase
				if ($urandom_range(0, 9) == 0)
					item.raw_codes = $urandom_range(0, 1) ? '1 : '0;
				send_item(item);
				sent++;
			end
			// At least once, halfway through, let every expected result come back
			// before sending more.
			if ((!paused_once && sent >= RANDOM_ITEMS / 2) || $urandom_range(0, 15) == 0) begin
				drain_scans();
				paused_once = 1'b1;
			end else begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
				if (gap > 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end

		drain_scans();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
